FILE: hdl/indexed_list_insert_delete_macros.svh
// Assertion macros used by the indexed list datapath.
`ifndef INDEXED_LIST_INSERT_DELETE_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ILID_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ILID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: hdl/ilid_pkg.sv
// Shared constants, types and command struct for the indexed list block.
package ilid_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int ACT_W   = 3;
  localparam int POS_W   = 8;
  localparam int DATA_W  = 32;
  localparam int OUT_CNT_W = 5;

  localparam int IN_FIELDS_W  = ACT_W + POS_W + DATA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DATA_W + 1 + OUT_CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_READ     = 3'd0,
    ACT_INS_HEAD = 3'd1,
    ACT_INS_TAIL = 3'd2,
    ACT_INS_AT   = 3'd3,
    ACT_DELETE   = 3'd4
  } action_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // apply the captured request and load the result register
  } cmd_t;

endpackage

FILE: hdl/ilid_ctrl.sv
// Controller: sequences request capture, execution and result hand-off.
module ilid_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output ilid_pkg::cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  assign cmd.load = (state_r == S_IDLE) && in_tvalid;
  assign cmd.exec = (state_r == S_EXEC) && slot_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/ilid_dpath.sv
// Datapath: request registers, row of entry cells, count and result register.
`include "indexed_list_insert_delete_macros.svh"

module ilid_dpath #(
  parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ilid_pkg::cmd_t                 cmd,
  input  logic [ilid_pkg::ACT_W-1:0]     action,
  input  logic [ilid_pkg::POS_W-1:0]     position,
  input  logic signed [ilid_pkg::DATA_W-1:0] data_in,
  output logic signed [ilid_pkg::DATA_W-1:0] data_out,
  output logic                           ok,
  output logic [ilid_pkg::OUT_CNT_W-1:0] count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > ilid_pkg::POS_W) ? CNT_W : ilid_pkg::POS_W;

  logic [ilid_pkg::ACT_W-1:0]          act_r;
  logic [ilid_pkg::POS_W-1:0]          pos_r;
  logic signed [ilid_pkg::DATA_W-1:0]  din_r;
  logic signed [ilid_pkg::DATA_W-1:0]  cells_r [CAPACITY];
  logic [CNT_W-1:0]                    count_r, count_nxt;

  logic signed [ilid_pkg::DATA_W-1:0]  data_out_r, data_nxt;
  logic                                ok_r, ok_nxt;
  logic [ilid_pkg::OUT_CNT_W-1:0]      count_out_r;

  logic [CMP_W-1:0] pos_x, cnt_x, ins_pos;
  logic             room, in_range, ins_en, del_en;

  assign pos_x    = CMP_W'(pos_r);
  assign cnt_x    = CMP_W'(count_r);
  assign room     = count_r < CNT_W'(CAPACITY);
  assign in_range = pos_x < cnt_x;

  // Decode the held request.
  always_comb begin
    ins_en   = 1'b0;
    del_en   = 1'b0;
    ins_pos  = pos_x;
    data_nxt = '0;
    case (ilid_pkg::action_t'(act_r))
      ilid_pkg::ACT_READ: begin
        data_nxt = in_range ? cells_r[pos_x[IDX_W-1:0]] : '1;
      end
      ilid_pkg::ACT_INS_HEAD: begin
        ins_en  = room;
        ins_pos = '0;
      end
      ilid_pkg::ACT_INS_TAIL: begin
        ins_en  = room;
        ins_pos = cnt_x;
      end
      ilid_pkg::ACT_INS_AT: begin
        ins_en = room && (pos_x <= cnt_x);
      end
      ilid_pkg::ACT_DELETE: begin
        del_en = in_range;
      end
      default: begin
        data_nxt = '0;
      end
    endcase
  end

  assign ok_nxt = ((ilid_pkg::action_t'(act_r) == ilid_pkg::ACT_READ) && in_range)
                  || ins_en || del_en;

  always_comb begin
    count_nxt = count_r;
    if (ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (del_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Later cells take the left neighbor on insert; the slot and later, the right on delete.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ilid_pkg::DATA_W-1:0] left_w, right_w;
    logic [CMP_W-1:0] idx_w;
    assign idx_w = CMP_W'(g);
    if (g == 0) begin : g_first
      assign left_w = din_r;
    end else begin : g_rest
      assign left_w = cells_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cells_r[g];
    end else begin : g_inner
      assign right_w = cells_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (ins_en && idx_w == ins_pos) begin
          cells_r[g] <= din_r;
        end else if (ins_en && idx_w > ins_pos) begin
          cells_r[g] <= left_w;
        end else if (del_en && idx_w >= pos_x) begin
          cells_r[g] <= right_w;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action;
      pos_r <= position;
      din_r <= data_in;
    end
    if (cmd.exec) begin
      data_out_r  <= data_nxt;
      ok_r        <= ok_nxt;
      count_out_r <= ilid_pkg::OUT_CNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign data_out = data_out_r;
  assign ok       = ok_r;
  assign count    = count_out_r;

  `ILID_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))
  `ILID_ASSERT_NEXT(a_ins_grows, cmd.exec && ins_en, count_r == $past(count_r) + CNT_W'(1))
  `ILID_ASSERT_NEXT(a_del_shrinks, cmd.exec && del_en, count_r == $past(count_r) - CNT_W'(1))
  `ILID_ASSERT_NEXT(a_idle_holds, !cmd.exec, $stable(count_r))

endmodule

FILE: hdl/indexed_list_insert_delete.sv
// Top level of the indexed ordered list with insert and delete.
//
// Holds an ordered list of up to CAPACITY signed 32-bit values in a row of
// register cells plus an entry count. Each input transaction is a request:
// read at a position, insert at the head, insert at the tail, insert before a
// position (a position equal to the count appends) or delete at a position.
// Every request yields exactly one result transaction carrying the value read
// (-1 for a read out of range, 0 for non-read requests), an ok flag and the
// count after the request, masked to 5 bits. Requests out of range, inserts
// into a full list and unknown action codes leave the list unchanged and
// return ok low. A request is captured at its accept edge, then applied and its
// result registered in the execute state once the result register is free. A
// new request is not accepted until the previous one has executed. The shift on
// insert or delete moves all later cells at once, in the execute state. The
// result register parts the two sides: the next request is accepted while a
// result still waits, and execution stalls only while the previous result is
// still untaken. No clearing pass after reset; entry contents are undefined
// until written and only positions below the count are ever read.
module indexed_list_insert_delete #(
  parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] action, [10:3] position, [42:11] data_in, rest zero
  input  logic [ilid_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] data_out, [32] ok, [37:33] count, rest zero
  output logic [ilid_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int POS_LO = ilid_pkg::ACT_W;
  localparam int DIN_LO = ilid_pkg::ACT_W + ilid_pkg::POS_W;

  ilid_pkg::cmd_t                           cmd;
  logic [ilid_pkg::ACT_W-1:0]               action;
  logic [ilid_pkg::POS_W-1:0]               position;
  logic signed [ilid_pkg::DATA_W-1:0]       data_in;
  logic signed [ilid_pkg::DATA_W-1:0]       data_out;
  logic                                     ok;
  logic [ilid_pkg::OUT_CNT_W-1:0]           count;

  // Unpack the request fields; padding bits are ignored.
  assign action   = in_tdata[ilid_pkg::ACT_W-1:0];
  assign position = in_tdata[POS_LO +: ilid_pkg::POS_W];
  assign data_in  = in_tdata[DIN_LO +: ilid_pkg::DATA_W];

  ilid_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ilid_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .action   (action),
    .position (position),
    .data_in  (data_in),
    .data_out (data_out),
    .ok       (ok),
    .count    (count)
  );

  // Pack the result, lowest field first, zero fill to a whole byte.
  assign out_tdata = ilid_pkg::OUT_TDATA_W'({count, ok, data_out});

endmodule
